[hw/rtl/sms_pkg.sv]
// ----------------------------------------------------------------------------
// sms_pkg
// Shared types and constants for the shutter move sequencer.
// ----------------------------------------------------------------------------
package sms_pkg;

	// move phases, encoded as reported on the result channel
	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_WAIT  = 3'd1,
		PH_MOVE  = 3'd2,
		PH_SPIKE = 3'd3,
		PH_CALIB = 3'd4
	} phase_t;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 1;
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_HOLD_TICKS  = 1'b0,
		CFG_SPIKE_TICKS = 1'b1
	} cfg_idx_t;

	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned SETTLE_W   = 16;
	localparam int unsigned TRAVEL_W   = 24;

	// reset values
	localparam logic [CFG_DATA_W-1:0] HOLD_RESET   = 16'd5000;
	localparam logic [CFG_DATA_W-1:0] SPIKE_RESET  = 16'd200;
	localparam int unsigned           TRAVEL_RESET = 10000;

endpackage

[hw/rtl/sms_if.sv]
// ----------------------------------------------------------------------------
// sms_cmd_if / sms_res_if
// Valid/ready channels for command ticks and sequencer results.
// ----------------------------------------------------------------------------
interface sms_cmd_if;
	logic valid;
	logic ready;
	logic cmd_up;
	logic cmd_down;

	modport source (output valid, output cmd_up, output cmd_down, input ready);
	modport sink   (input valid, input cmd_up, input cmd_down, output ready);
endinterface

interface sms_res_if;
	logic        valid;
	logic        ready;
	logic        relay_up;
	logic        relay_down;
	logic [2:0]  phase;
	logic [23:0] travel_time;
	logic        calib_done;

	modport source (
		output valid, output relay_up, output relay_down, output phase,
		output travel_time, output calib_done, input ready
	);
	modport sink (
		input valid, input relay_up, input relay_down, input phase,
		input travel_time, input calib_done, output ready
	);
endinterface

[hw/rtl/shutter_move_sequencer.sv]
// ----------------------------------------------------------------------------
// shutter_move_sequencer
// Relay sequencer for a motorized shutter, one command request per tick.
// ----------------------------------------------------------------------------
// result: valid in the cycle after its command request is accepted
// throughput: one request per cycle while the result side is ready; the state
//   update is a single registered pass (counter increment and compares) and
//   the result register refills in the cycle it is taken
// reset: phase idle, relays off, counters zero, travel time 10000,
//   hold limit 5000, spike filter 200, no result pending
module shutter_move_sequencer
	import sms_pkg::*;
#(
	parameter int unsigned COUNT_WIDTH = 24
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	sms_cmd_if.sink               cmd,
	sms_res_if.source             res
);

	localparam logic [COUNT_WIDTH-1:0] CNT_MAX    = {COUNT_WIDTH{1'b1}};
	localparam logic [SETTLE_W-1:0]    SETTLE_MAX = {SETTLE_W{1'b1}};

	// configuration
	logic [CFG_DATA_W-1:0] hold_q;
	logic [CFG_DATA_W-1:0] spike_q;

	// sequencer state
	phase_t                 phase_q, phase_n;
	logic [COUNT_WIDTH-1:0] press_q, press_n, press_inc;
	logic [SETTLE_W-1:0]    settle_q, settle_n;
	logic [COUNT_WIDTH-1:0] travel_q, travel_n;
	logic                   up_q, up_n;
	logic                   down_q, down_n;
	logic                   done_n;

	// result register
	logic                   out_valid_q;
	logic                   out_up_q;
	logic                   out_down_q;
	phase_t                 out_phase_q;
	logic [TRAVEL_W-1:0]    out_travel_q;
	logic                   out_done_q;

	logic in_fire;
	logic none;
	logic single;

	assign cmd.ready = !out_valid_q || res.ready;
	assign in_fire   = cmd.valid && cmd.ready;
	assign none      = !cmd.cmd_up && !cmd.cmd_down;
	assign single    = cmd.cmd_up ^ cmd.cmd_down;
	assign press_inc = (press_q == CNT_MAX) ? press_q : press_q + 1'b1;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q  <= HOLD_RESET;
			spike_q <= SPIKE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_HOLD_TICKS:  hold_q  <= cfg_data;
				CFG_SPIKE_TICKS: spike_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// next phase
	always_comb begin
		phase_n = phase_q;
		unique case (phase_q)
			PH_IDLE: begin
				if (single) phase_n = PH_WAIT;
			end
			PH_WAIT: begin
				// release wins over the hold limit on the same tick
				priority if (none)                             phase_n = PH_MOVE;
				else if (press_inc > COUNT_WIDTH'(hold_q))     phase_n = PH_CALIB;
			end
			PH_MOVE: begin
				if (press_inc >= travel_q || !none) phase_n = PH_SPIKE;
			end
			PH_SPIKE: begin
				if (none && settle_q >= spike_q) phase_n = PH_IDLE;
			end
			PH_CALIB: begin
				if (none) phase_n = PH_SPIKE;
			end
			default: phase_n = PH_IDLE;
		endcase
	end

	// counters, relays and learned travel time
	always_comb begin
		press_n  = press_q;
		settle_n = settle_q;
		travel_n = travel_q;
		up_n     = up_q;
		down_n   = down_q;
		done_n   = 1'b0;
		unique case (phase_q)
			PH_IDLE: begin
				up_n   = cmd.cmd_up & single;
				down_n = cmd.cmd_down & single;
				if (single) press_n = '0;
			end
			PH_WAIT: begin
				press_n = press_inc;
			end
			PH_MOVE: begin
				press_n = press_inc;
				if (press_inc >= travel_q || !none) begin
					up_n     = 1'b0;
					down_n   = 1'b0;
					settle_n = '0;
				end
			end
			PH_SPIKE: begin
				priority if (none && settle_q >= spike_q) settle_n = '0;
				else if (settle_q != SETTLE_MAX)          settle_n = settle_q + 1'b1;
			end
			PH_CALIB: begin
				press_n = press_inc;
				if (none) begin
					travel_n = press_inc;
					done_n   = 1'b1;
					settle_n = '0;
				end
			end
			default: ;
		endcase
	end

	// state update per accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			press_q  <= '0;
			settle_q <= '0;
			travel_q <= COUNT_WIDTH'(TRAVEL_RESET);
			up_q     <= 1'b0;
			down_q   <= 1'b0;
		end else if (in_fire) begin
			phase_q  <= phase_n;
			press_q  <= press_n;
			settle_q <= settle_n;
			travel_q <= travel_n;
			up_q     <= up_n;
			down_q   <= down_n;
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (in_fire) begin
			out_up_q     <= up_n;
			out_down_q   <= down_n;
			out_phase_q  <= phase_n;
			out_travel_q <= TRAVEL_W'(travel_n);
			out_done_q   <= done_n;
		end
	end

	assign res.valid       = out_valid_q;
	assign res.relay_up    = out_up_q;
	assign res.relay_down  = out_down_q;
	assign res.phase       = out_phase_q;
	assign res.travel_time = out_travel_q;
	assign res.calib_done  = out_done_q;

	// relays are never driven against each other
	a_relay_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(up_q && down_q))
		else $error("both relays driven");

	// a stored travel time is always reported in the spike filter phase
	a_done_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.calib_done) |-> (res.phase == PH_SPIKE))
		else $error("calibration done outside spike filter");

	// starting a move clears the press counter
	a_move_start: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && phase_q == PH_IDLE && single) |=> (press_q == '0 && phase_q == PH_WAIT))
		else $error("move start did not clear press counter");

	// state only advances on an accepted request
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!in_fire |=> ($stable(phase_q) && $stable(travel_q)))
		else $error("state changed without a request");

	// a running move drives exactly one relay
	a_move_one: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.phase == PH_MOVE) |-> (res.relay_up != res.relay_down))
		else $error("move without exactly one relay");

endmodule

[tb/shutter_move_sequencer_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// shutter_move_sequencer_checker
// Watches the command and result channels and the register port. Keeps its
// own copy of the relay sequencer state, predicts the result of every
// accepted command request and compares it field by field with what the
// block returns.
// ----------------------------------------------------------------------------
module shutter_move_sequencer_checker
	import sms_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	sms_cmd_if                    cmd,
	sms_res_if                    res,
	output int                    fail_count,
	output int                    pending
);

	typedef struct packed {
		logic                relay_up;
		logic                relay_down;
		phase_t              phase;
		logic [TRAVEL_W-1:0] travel_time;
		logic                calib_done;
	} shutter_out_t;

	// predicted sequencer state and register copies
	logic [CFG_DATA_W-1:0] hold_cfg;
	logic [CFG_DATA_W-1:0] spike_cfg;
	phase_t                phase_now;
	logic [TRAVEL_W-1:0]   press_count;
	logic [SETTLE_W-1:0]   settle_count;
	logic [TRAVEL_W-1:0]   travel_learned;
	logic                  up_on;
	logic                  down_on;

	shutter_out_t outputs_due[$];

	// one tick of the sequencer, returns the outputs after the update
	function automatic shutter_out_t advance_sequencer(input logic up, input logic down);
		logic         released;
		shutter_out_t r;
		released = !up && !down;
		r.calib_done = 1'b0;

		// press counter runs in wait, moving and calibrating, saturating
		if ((phase_now == PH_WAIT || phase_now == PH_MOVE || phase_now == PH_CALIB) &&
				press_count != '1)
			press_count++;

		case (phase_now)
			PH_IDLE: begin
				up_on   = 1'b0;
				down_on = 1'b0;
				// exactly one command starts a move
				if (up != down) begin
					up_on       = up;
					down_on     = down;
					press_count = '0;
					phase_now   = PH_WAIT;
				end
			end
			PH_WAIT: begin
				if (press_count > hold_cfg)
					phase_now = PH_CALIB;
				// release wins over the hold limit
				if (released)
					phase_now = PH_MOVE;
			end
			PH_MOVE: begin
				if (press_count >= travel_learned || !released) begin
					up_on        = 1'b0;
					down_on      = 1'b0;
					settle_count = '0;
					phase_now    = PH_SPIKE;
				end
			end
			PH_SPIKE: begin
				if (released && settle_count >= spike_cfg) begin
					settle_count = '0;
					phase_now    = PH_IDLE;
				end else if (settle_count != '1) begin
					settle_count++;
				end
			end
			PH_CALIB: begin
				if (released) begin
					travel_learned = press_count;
					r.calib_done   = 1'b1;
					settle_count   = '0;
					phase_now      = PH_SPIKE;
				end
			end
			default: phase_now = PH_IDLE;
		endcase

		r.relay_up    = up_on;
		r.relay_down  = down_on;
		r.phase       = phase_now;
		r.travel_time = travel_learned;
		return r;
	endfunction

	// compare results, track register writes, predict new requests
	always @(posedge clk or negedge arst_n) begin : seq_check
		shutter_out_t want;
		if (!arst_n) begin
			hold_cfg       = HOLD_RESET;
			spike_cfg      = SPIKE_RESET;
			phase_now      = PH_IDLE;
			press_count    = '0;
			settle_count   = '0;
			travel_learned = TRAVEL_W'(TRAVEL_RESET);
			up_on          = 1'b0;
			down_on        = 1'b0;
			outputs_due.delete();
			fail_count     = 0;
		end else begin
			if (res.valid && res.ready) begin
				if (outputs_due.size() == 0) begin
					$error("result with no request outstanding");
					fail_count++;
				end else begin
					want = outputs_due.pop_front();
					if (res.relay_up !== want.relay_up) begin
						$error("relay_up: expected %0d, got %0d", want.relay_up, res.relay_up);
						fail_count++;
					end
					if (res.relay_down !== want.relay_down) begin
						$error("relay_down: expected %0d, got %0d",
							want.relay_down, res.relay_down);
						fail_count++;
					end
					if (res.phase !== want.phase) begin
						$error("phase: expected %0d, got %0d", want.phase, res.phase);
						fail_count++;
					end
					if (res.travel_time !== want.travel_time) begin
						$error("travel_time: expected %0d, got %0d",
							want.travel_time, res.travel_time);
						fail_count++;
					end
					if (res.calib_done !== want.calib_done) begin
						$error("calib_done: expected %0d, got %0d",
							want.calib_done, res.calib_done);
						fail_count++;
					end
				end
			end

			if (cfg_we) begin
				case (cfg_idx_t'(cfg_index))
					CFG_HOLD_TICKS:  hold_cfg  = cfg_data;
					CFG_SPIKE_TICKS: spike_cfg = cfg_data;
					default: ;
				endcase
			end

			if (cmd.valid && cmd.ready)
				outputs_due.push_back(advance_sequencer(cmd.cmd_up, cmd.cmd_down));
		end
		pending = outputs_due.size();
	end

endmodule

[tb/shutter_move_sequencer_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// shutter_move_sequencer_tb
// Drives command ticks into the shutter move sequencer: a short directed
// sequence over each phase and corner, then random press, release, stop and
// calibration sequences under several hold and spike settings. Both channels
// idle and stall at random. The checker beside the block predicts and
// compares every result.
// ----------------------------------------------------------------------------
module shutter_move_sequencer_tb;
	import sms_pkg::*;

	localparam int unsigned CYCLE_LIMIT  = 2_000_000;
	localparam int          PHASE_TICKS  = 225;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    fail_count;
	int                    pending;
	int                    ticks_sent;
	logic                  calm_source;
	logic                  calm_sink;

	sms_cmd_if cmd();
	sms_res_if res();

	shutter_move_sequencer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.res       (res)
	);

	shutter_move_sequencer_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.cmd        (cmd),
		.res        (res),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// directed ticks, bit 1 up and bit 0 down, run with hold 1 and spike 0:
	// both in idle, move stopped by second press, release right at the hold
	// limit, calibration to a travel of 4, move stopped by travel time
	logic [1:0] directed_ticks [25] = '{
		2'b11, 2'b00, 2'b10, 2'b00, 2'b00, 2'b01, 2'b01, 2'b00, 2'b01, 2'b01,
		2'b00, 2'b11, 2'b00, 2'b10, 2'b10, 2'b10, 2'b11, 2'b00, 2'b00, 2'b01,
		2'b00, 2'b00, 2'b00, 2'b00, 2'b00
	};

	logic [CFG_DATA_W-1:0] hold_set  [6] = '{16'd0, 16'd7, 16'd25, 16'd3, 16'd40, 16'd12};
	logic [CFG_DATA_W-1:0] spike_set [6] = '{16'd1, 16'd0, 16'd12, 16'd30, 16'd4, 16'd6};

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// mostly no gap, some short, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 31);
		if (r < 18)
			return 0;
		else if (r < 29)
			return $urandom_range(1, 3);
		else
			return $urandom_range(10, 40);
	endfunction

	// one command request, entered and left at a falling edge
	task automatic send_tick(input logic up, input logic down);
		int gap;
		gap = calm_source ? 0 : pick_gap();
		if (gap > 0) begin
			cmd.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd.valid    <= 1'b1;
		cmd.cmd_up   <= up;
		cmd.cmd_down <= down;
		do @(posedge clk); while (!cmd.ready);
		ticks_sent++;
		@(negedge clk);
	endtask

	// hold off until every result is back
	task automatic drain();
		cmd.valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(negedge clk);
		cfg_we    <= 1'b0;
		@(negedge clk);
	endtask

	// one random episode: noise ticks, or a press, release, optional stop press, settle
	task automatic run_episode(input int hold, input int spike);
		int   kind;
		int   len;
		logic up_dir;
		kind   = $urandom_range(0, 9);
		up_dir = 1'($urandom_range(0, 1));
		calm_source = ($urandom_range(0, 3) == 0);
		calm_sink   = ($urandom_range(0, 3) == 0);
		if ($urandom_range(0, 9) == 0)
			drain();

		if (kind == 0) begin
			// noise, both commands in idle among it
			repeat ($urandom_range(1, 12))
				send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
		end else begin
			// short press moves, longer press calibrates in most cases
			len = (kind < 6) ? $urandom_range(1, hold + 1) : hold + $urandom_range(1, 15);
			for (int i = 0; i < len; i++) begin
				if (kind == 9 && $urandom_range(0, 3) == 0)
					send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
				else
					send_tick(up_dir, !up_dir);
			end
			// release, long enough at times for the travel time to run out
			repeat ($urandom_range(0, 50))
				send_tick(1'b0, 1'b0);
			// second press stops the move
			if ($urandom_range(0, 1) == 1) begin
				repeat ($urandom_range(1, 4)) begin
					if ($urandom_range(0, 2) == 0)
						send_tick(1'b1, 1'b1);
					else
						send_tick(up_dir, !up_dir);
				end
			end
			// spike filter with an occasional glitch
			repeat ($urandom_range(0, spike + 10)) begin
				if ($urandom_range(0, 9) == 0)
					send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
				else
					send_tick(1'b0, 1'b0);
			end
		end
	endtask

	// result side, random stalls
	initial begin : result_sink
		int stall_left;
		stall_left = 0;
		res.ready  = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0 && !calm_sink) begin
				res.ready <= 1'b0;
				stall_left--;
			end else begin
				res.ready <= 1'b1;
				stall_left = calm_sink ? 0 : pick_gap();
			end
		end
	end

	// run limit
	initial begin : watchdog
		int unsigned cycles;
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	// stimulus and verdict
	initial begin : stimulus
		int goal;
		logic [CFG_DATA_W-1:0] hold_val;
		logic [CFG_DATA_W-1:0] spike_val;
		arst_n       = 1'b0;
		cmd.valid    = 1'b0;
		cmd.cmd_up   = 1'b0;
		cmd.cmd_down = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = CFG_HOLD_TICKS;
		cfg_data     = '0;
		ticks_sent   = 0;
		calm_source  = 1'b0;
		calm_sink    = 1'b0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed corners at hold 1 and spike 0
		write_reg(CFG_HOLD_TICKS, 16'd1);
		write_reg(CFG_SPIKE_TICKS, 16'd0);
		foreach (directed_ticks[i])
			send_tick(directed_ticks[i][1], directed_ticks[i][0]);

		// random moves under several settings, the last one random
		for (int ph = 0; ph < 6; ph++) begin
			hold_val  = (ph == 5) ? CFG_DATA_W'($urandom_range(1, 50)) : hold_set[ph];
			spike_val = (ph == 5) ? CFG_DATA_W'($urandom_range(0, 20)) : spike_set[ph];
			drain();
			write_reg(CFG_HOLD_TICKS, hold_val);
			write_reg(CFG_SPIKE_TICKS, spike_val);
			goal = ticks_sent + PHASE_TICKS;
			while (ticks_sent < goal)
				run_episode(int'(hold_val), int'(spike_val));
		end

		drain();
		repeat (10) @(negedge clk);
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

[sim.f]
hw/rtl/sms_pkg.sv
hw/rtl/sms_if.sv
hw/rtl/shutter_move_sequencer.sv
tb/shutter_move_sequencer_checker.sv
tb/shutter_move_sequencer_tb.sv
